@@ hw/rtl/spq_pkg.sv @@
// shared constants, types and helpers for the sorted min-priority queue
// no dependencies; imported by every module of the block
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned TDATA_W  = ((DATA_W + OCC_W + 7) / 8) * 8;
  localparam int unsigned TUSER_W  = 2;

  // op codes carried on the input tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // one access to the key memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // finished result of one word
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     empty;
    logic                     dropped;
    logic [OCC_W-1:0]         occupancy;
  } res_t;

  // logical slot to physical address in the circular store
  function automatic logic [ADDR_W-1:0] spq_phys(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] slot);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, slot};
    if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
      sum = sum - (ADDR_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sorted_min_priority_queue.sv @@
// top level of the sorted min-priority queue: stream ports and output register
// depends on spq_pkg, spq_ram and spq_seq
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   [31:0] value                            [0] op (0 insert, 1 pop)
//  m_axis    out  [31:0] popped_value, [36:32] occupancy  [0] was_empty,
//                 [39:37] zero                                [1] insert_dropped
//
// keys sit in a circular store, smallest at the head pointer
// pop of a non-empty queue: read, retire, deliver
// insert: one compare-and-move step per stored key larger than the new one, each done by the
//   single compare unit and the one read port of the store
// empty pop, full insert and insert into an empty queue: straight to deliver
// reset clears the count, head, sequencer state and output valid; the store needs no clearing
// a finished word waits in the output register; the next word is taken meanwhile,
//   and the sequencer holds its result only while that register is still full
`default_nettype none

module sorted_min_priority_queue
  import spq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  input  wire logic [DATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  wire logic               s_axis_tuser_i,   // [0] op
  output      logic               m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output      logic [TDATA_W-1:0] m_axis_tdata_o,   // [31:0] popped_value, [36:32] occupancy
  output      logic [TUSER_W-1:0] m_axis_tuser_o    // [0] was_empty, [1] insert_dropped
);

  logic              in_acc;
  logic              seq_ready;
  logic              res_valid;
  res_t              res;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              out_free;

  logic               m_valid_q, m_valid_d;
  logic [TDATA_W-1:0] m_data_q, m_data_d;
  logic [TUSER_W-1:0] m_user_q, m_user_d;

  assign in_acc          = s_axis_tvalid_i && seq_ready;
  assign s_axis_tready_o = seq_ready;

  // output slot frees when empty or when its word is taken this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  spq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  spq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .op_i        (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i),
    .out_free_i  (out_free),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (res_valid && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = TDATA_W'({res.occupancy, res.value});
      m_user_d  = {res.dropped, res.empty};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  // the queue never reports more keys than it can hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DATA_W +: OCC_W] <= OCC_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // a word is never both an empty pop and a dropped insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("empty and dropped flags together");

  // an empty pop returns zero and leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[DATA_W-1:0] == '0 && m_axis_tdata_o[DATA_W +: OCC_W] == '0))
    else $error("empty pop with data or occupancy");

  // the sequencer is busy in the cycle after it takes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // a result is never loaded over a word that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> $stable(m_data_q))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
// key store: one write port, one read port with registered read data
// depends on spq_pkg
`default_nettype none

module spq_ram
  import spq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire ram_req_t          req_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/spq_seq.sv @@
// sequencer: walks the sorted store one slot a cycle with a shared comparator
// depends on spq_pkg; drives the key memory through a ram_req_t
`default_nettype none

module spq_seq
  import spq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     op_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     out_free_i,
  output      logic                     ready_o,
  output      logic                     res_valid_o,
  output      res_t                     res_o,
  output      ram_req_t                 ram_req_o,
  input  wire logic        [DATA_W-1:0] ram_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_CMP  = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     empty_q, empty_d;
  logic                     drop_q, drop_d;

  logic signed [DATA_W-1:0] rd_s;
  logic                     rd_greater;
  logic [CNT_W-1:0]         count_m1;

  assign rd_s       = ram_rdata_i;
  assign rd_greater = rd_s > key_q;   // the shared compare unit
  assign count_m1   = count_q - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    val_d     = val_q;
    empty_d   = empty_q;
    drop_d    = drop_q;
    ram_req_o = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d   = '0;
          empty_d = 1'b0;
          drop_d  = 1'b0;
          key_d   = value_i;
          if (op_i == OP_POP) begin
            if (count_q == '0) begin
              empty_d = 1'b1;
              state_d = S_DONE;
            end else begin
              ram_req_o.raddr = head_q;
              state_d         = S_POP;
            end
          end else if (count_q == CNT_W'(CAPACITY)) begin
            drop_d  = 1'b1;
            state_d = S_DONE;
          end else if (count_q == '0) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = head_q;
            ram_req_o.wdata = value_i;
            count_d         = count_q + CNT_W'(1);
            state_d         = S_DONE;
          end else begin
            // start at the tail and move larger keys up one slot
            idx_d           = count_q[ADDR_W-1:0];
            ram_req_o.raddr = spq_phys(head_q, count_m1[ADDR_W-1:0]);
            state_d         = S_CMP;
          end
        end
      end
      S_POP: begin
        val_d   = rd_s;
        head_d  = spq_phys(head_q, ADDR_W'(1));
        count_d = count_m1;
        state_d = S_DONE;
      end
      S_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = spq_phys(head_q, idx_q);
        if (rd_greater) begin
          ram_req_o.wdata = ram_rdata_i;
          idx_d           = idx_q - ADDR_W'(1);
          if (idx_q == ADDR_W'(1)) begin
            state_d = S_PUT;
          end else begin
            ram_req_o.raddr = spq_phys(head_q, idx_q - ADDR_W'(2));
          end
        end else begin
          // equal keys stay ahead of the new one
          ram_req_o.wdata = key_q;
          count_d         = count_q + CNT_W'(1);
          state_d         = S_DONE;
        end
      end
      S_PUT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = head_q;
        ram_req_o.wdata = key_q;
        count_d         = count_q + CNT_W'(1);
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    key_q   <= key_d;
    val_q   <= val_d;
    empty_q <= empty_d;
    drop_q  <= drop_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{value: val_q, empty: empty_q, dropped: drop_q,
                         occupancy: OCC_W'(count_q)};

endmodule

`default_nettype wire

@@ test/sorted_min_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the sorted min-priority queue: directed, random and stall words
// depends on spq_pkg and the sorted_min_priority_queue rtl; keeps its own sorted key list

module sorted_min_priority_queue_tb
  import spq_pkg::*;
();

  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in the stall test
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 200;
  localparam int PHASE_WORDS  = 195;

  localparam logic [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [DATA_W-1:0]  s_axis_tdata_i  = '0;         // [31:0] value
  logic               s_axis_tuser_i  = OP_INSERT;  // [0] op
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;               // [31:0] popped_value, [36:32] occupancy
  logic [TUSER_W-1:0] m_axis_tuser_o;               // [0] was_empty, [1] insert_dropped

  // keys the queue should hold, ascending; results still owed by the block
  logic signed [DATA_W-1:0] held_keys[$];
  res_t                     owed_results[$];

  int error_count  = 0;
  int stall_cycles = 0;
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit rx_hold_req  = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_min_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // applies one accepted word to the key list and returns the word the block owes
  function automatic res_t queue_apply(input logic op, input logic signed [DATA_W-1:0] key);
    res_t r;
    int   pos;
    r   = '0;
    pos = 0;
    if (op == OP_INSERT) begin
      if (held_keys.size() >= CAPACITY) begin
        r.dropped = 1'b1;
      end else begin
        // a new key goes behind every equal key
        while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
        held_keys.insert(pos, key);
      end
    end else if (held_keys.size() == 0) begin
      r.empty = 1'b1;
    end else begin
      r.value = held_keys.pop_front();
    end
    r.occupancy = OCC_W'(held_keys.size());
    return r;
  endfunction

  // mix of wide random keys, small keys with many ties, and keys near both ends
  function automatic logic [DATA_W-1:0] draw_key();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      2: begin
        case ($urandom_range(0, 4))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return '0;
          3: return '1;
          default: return DATA_W'(1);
        endcase
      end
      3: return KEY_MIN | DATA_W'($urandom_range(0, 255));
      4: return KEY_MAX ^ DATA_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic draw_op(input int insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
  endfunction

  // predict at the input handshake
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      owed_results.push_back(queue_apply(s_axis_tuser_i, s_axis_tdata_i));
    end
  end

  // check every word leaving the block against the oldest owed one
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.value     = m_axis_tdata_o[DATA_W-1:0];
      got.occupancy = m_axis_tdata_o[DATA_W +: OCC_W];
      got.empty     = m_axis_tuser_o[0];
      got.dropped   = m_axis_tuser_o[1];
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected word, got value %0d empty %b dropped %b occupancy %0d",
                   $time, got.value, got.empty, got.dropped, got.occupancy);
        end
      end else begin
        want = owed_results.pop_front();
        if (want != got) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected value %0d empty %b dropped %b occupancy %0d",
                     $time, want.value, want.empty, want.dropped, want.occupancy);
            $display("%0t:            actual value %0d empty %b dropped %b occupancy %0d",
                     $time, got.value, got.empty, got.dropped, got.occupancy);
          end
        end
      end
    end
  end

  // receiver: random wait per word, or one long hold-off on request
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // offers one word, after a random gap when tx_idle is set; returns at the edge where it is taken
  task automatic send_word(input logic op, input logic [DATA_W-1:0] key);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= key;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic apply_reset();
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // empty pops, both ends of the key range, ties at min, zero and max, ignored pop value
  task automatic test_extremes_and_ties();
    send_word(OP_POP, '0);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, DATA_W'(1));
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_POP, '1);
    repeat (7) send_word(OP_POP, '0);
    send_word(OP_POP, 32'h5a5a_a5a5);
  endtask

  // fill past capacity so inserts get dropped, then pop past empty
  task automatic test_fill_and_drop();
    tx_idle = 1'b0;
    repeat (CAPACITY + 2) send_word(OP_INSERT, draw_key());
    tx_idle = 1'b1;
    repeat (CAPACITY + 2) send_word(OP_POP, $urandom);
  endtask

  // phases that lean toward filling, draining or neither, each with its own idling
  task automatic test_random_mix();
    int insert_pct;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 75;
      endcase
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      repeat (PHASE_WORDS) send_word(draw_op(insert_pct), draw_key());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off for a long stretch while words keep coming, so the input stalls
  task automatic test_output_stall();
    tx_idle     = 1'b0;
    rx_hold_req = 1'b1;
    repeat (48) send_word(draw_op(75), draw_key());
    tx_idle = 1'b1;
  endtask

  initial begin
    apply_reset();
    test_extremes_and_ties();
    test_fill_and_drop();
    test_random_mix();
    test_output_stall();
    s_axis_tvalid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sorted_min_priority_queue.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_seq.sv
hw/rtl/sorted_min_priority_queue.sv
test/sorted_min_priority_queue_tb.sv
